>>> rtl/core/motor_command_deadzone_normalizer_core_assert.svh
// Assertion macros shared by the deadzone normalizer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MOTOR_COMMAND_DEADZONE_NORMALIZER_CORE_ASSERT_SVH
`define MOTOR_COMMAND_DEADZONE_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MCDN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MCDN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mcdn_pkg.sv
// Package of the motor command deadzone normalizer: field widths, register
// indexes, reset values and the divider step count. Depends on nothing.
package mcdn_pkg;

    // Four motor lanes per beat.
    localparam int N_MOTORS = 4;

    // Configuration register widths.
    localparam int THR_W = 12;
    localparam int OFF_W = 12;
    localparam int LIM_W = 15;

    // The quotient never exceeds the limit, so one step per limit bit.
    localparam int DIV_STEPS = LIM_W;

    // Register indexes on the write port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd6;

    // Reset values of the unsigned registers.
    localparam logic [THR_W-1:0] THR_RESET = 12'd30;
    localparam logic [OFF_W-1:0] OFF_RESET = 12'd200;
    localparam logic [LIM_W-1:0] LIM_RESET = 15'd10000;

    // Quotient and dividend low bits as they move through the divider.
    typedef logic [DIV_STEPS-1:0] t_quo;

endpackage

>>> rtl/core/mcdn_ifs.sv
// Valid/ready channel interfaces for the command beats in and out.
// Depends on nothing; the command width is a parameter of each interface.
interface mcdn_in_if #(parameter int CMD_WIDTH = 16);
    logic                        valid;
    logic                        ready;
    logic signed [CMD_WIDTH-1:0] motor_a_in;
    logic signed [CMD_WIDTH-1:0] motor_b_in;
    logic signed [CMD_WIDTH-1:0] motor_c_in;
    logic signed [CMD_WIDTH-1:0] motor_d_in;

    modport source (
        output valid, motor_a_in, motor_b_in, motor_c_in, motor_d_in,
        input  ready
    );
    modport sink (
        input  valid, motor_a_in, motor_b_in, motor_c_in, motor_d_in,
        output ready
    );
endinterface

interface mcdn_out_if #(parameter int CMD_WIDTH = 16);
    logic                        valid;
    logic                        ready;
    logic signed [CMD_WIDTH-1:0] motor_a_out;
    logic signed [CMD_WIDTH-1:0] motor_b_out;
    logic signed [CMD_WIDTH-1:0] motor_c_out;
    logic signed [CMD_WIDTH-1:0] motor_d_out;
    logic                        was_scaled;

    modport source (
        output valid, motor_a_out, motor_b_out, motor_c_out, motor_d_out, was_scaled,
        input  ready
    );
    modport sink (
        input  valid, motor_a_out, motor_b_out, motor_c_out, motor_d_out, was_scaled,
        output ready
    );
endinterface

>>> rtl/core/mcdn_div_step.sv
// One registered restoring-division step for all four lanes.
// Depends on mcdn_pkg for the lane count and the quotient type.
module mcdn_div_step
    import mcdn_pkg::*;
#(
    parameter int MAG_W = 16
)
(
    input  logic             i_clk,
    input  logic             i_ld,
    input  logic [MAG_W-1:0] i_max,
    input  logic [MAG_W-1:0] i_rem [N_MOTORS],
    input  t_quo             i_low [N_MOTORS],
    input  t_quo             i_quo [N_MOTORS],
    output logic [MAG_W-1:0] o_max,
    output logic [MAG_W-1:0] o_rem [N_MOTORS],
    output t_quo             o_low [N_MOTORS],
    output t_quo             o_quo [N_MOTORS]
);

    logic [MAG_W:0]   w_trial [N_MOTORS];
    logic [MAG_W:0]   w_diff  [N_MOTORS];
    logic             w_take  [N_MOTORS];
    logic [MAG_W-1:0] n_rem   [N_MOTORS];
    t_quo             n_low   [N_MOTORS];
    t_quo             n_quo   [N_MOTORS];

    logic [MAG_W-1:0] r_max;
    logic [MAG_W-1:0] r_rem [N_MOTORS];
    t_quo             r_low [N_MOTORS];
    t_quo             r_quo [N_MOTORS];

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        for (int i = 0; i < N_MOTORS; i++) begin
            w_trial[i] = {i_rem[i], i_low[i][DIV_STEPS-1]};
            w_diff[i]  = w_trial[i] - {1'b0, i_max};
            w_take[i]  = (w_trial[i] >= {1'b0, i_max});
            n_rem[i]   = w_take[i] ? w_diff[i][MAG_W-1:0] : w_trial[i][MAG_W-1:0];
            n_low[i]   = {i_low[i][DIV_STEPS-2:0], 1'b0};
            n_quo[i]   = {i_quo[i][DIV_STEPS-2:0], w_take[i]};
        end
    end

    // Stage register, held while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_max <= i_max;
            r_rem <= n_rem;
            r_low <= n_low;
            r_quo <= n_quo;
        end
    end

    assign o_max = r_max;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_quo = r_quo;

endmodule

>>> rtl/core/motor_command_deadzone_normalizer_core.sv
// Channel  | Port         | Direction | Payload
// ---------+--------------+-----------+------------------------------------------------
// command  | i_cmd        | in        | motor_a_in..motor_d_in, signed CMD_WIDTH
// result   | o_cmd        | out       | motor_a_out..motor_d_out, signed; was_scaled
// config   | i_cfg_*      | in        | write enable, 3-bit index, write data
//
// The pipeline holds the deadzone stage, the max/multiply stage, fifteen divider
// steps (one quotient bit each) and the saturating output register.
// One beat is accepted every cycle unless the pipeline is full and the output stalls;
// every stage holds a valid bit and loads whenever it is empty or the stage after it moves, so bubbles close up.
// A stall at the output backs up stage by stage without losing a beat.
// Reset is synchronous; it clears the valid bits and returns the configuration to its reset values.
`include "motor_command_deadzone_normalizer_core_assert.svh"

module motor_command_deadzone_normalizer_core
    import mcdn_pkg::*;
#(
    parameter int CMD_WIDTH = 16
)
(
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                                  i_cfg_idx,
    input  logic [((CMD_WIDTH > LIM_W) ? CMD_WIDTH : LIM_W)-1:0]  i_cfg_wdata,
    mcdn_in_if.sink                                               i_cmd,
    mcdn_out_if.source                                            o_cmd
);

    // Magnitude after the deadzone offset, one sign bit more for arithmetic.
    localparam int MAG_W  = (CMD_WIDTH > OFF_W + 1) ? CMD_WIDTH : OFF_W + 1;
    localparam int EXT_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + LIM_W;
    localparam int FIN_W  = (MAG_W > LIM_W) ? MAG_W : LIM_W;
    localparam int NSTG   = DIV_STEPS + 3;
    localparam int OUT_S  = NSTG - 1;
    localparam int DIV0   = 2;
    localparam logic [FIN_W-1:0] BOUND = FIN_W'((64'd1 << (CMD_WIDTH - 1)) - 64'd1);

    // Configuration registers.
    logic signed [CMD_WIDTH-1:0] r_forced [N_MOTORS];
    logic [THR_W-1:0]            r_thr;
    logic [OFF_W-1:0]            r_off;
    logic [LIM_W-1:0]            r_lim;

    // Pipeline control.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_ld;

    // Stage 1: deadzone or forced command as sign and magnitude.
    logic signed [CMD_WIDTH-1:0] w_in [N_MOTORS];
    logic                        w_forced;
    logic                        n_s1_sign [N_MOTORS];
    logic [MAG_W-1:0]            n_s1_mag  [N_MOTORS];
    logic                        r_s1_sign [N_MOTORS];
    logic [MAG_W-1:0]            r_s1_mag  [N_MOTORS];

    // Stage 2: largest magnitude, scale flag and dividends.
    logic [MAG_W-1:0]  w_max01;
    logic [MAG_W-1:0]  w_max23;
    logic              n_s2_scl;
    logic              r_s2_sign [N_MOTORS];
    logic [MAG_W-1:0]  r_s2_mag  [N_MOTORS];
    logic [PROD_W-1:0] r_s2_prod [N_MOTORS];
    logic [MAG_W-1:0]  r_s2_max;
    logic              r_s2_scl;

    // Divider chain; index 0 is the entry, index k+1 the output of step k.
    logic [MAG_W-1:0] w_dmax [DIV_STEPS+1];
    logic [MAG_W-1:0] w_drem [DIV_STEPS+1][N_MOTORS];
    t_quo             w_dlow [DIV_STEPS+1][N_MOTORS];
    t_quo             w_dquo [DIV_STEPS+1][N_MOTORS];

    // Sign, magnitude and scale flag travel beside the divider.
    logic             r_sd_sign [DIV_STEPS][N_MOTORS];
    logic [MAG_W-1:0] r_sd_mag  [DIV_STEPS][N_MOTORS];
    logic             r_sd_scl  [DIV_STEPS];

    // Output stage.
    logic [FIN_W-1:0]            w_fin_mag [N_MOTORS];
    logic [CMD_WIDTH-1:0]        w_fin_pos [N_MOTORS];
    logic signed [CMD_WIDTH-1:0] n_out     [N_MOTORS];
    logic signed [CMD_WIDTH-1:0] r_out     [N_MOTORS];
    logic                        r_out_scl;

    // Checks on the divider result.
    logic w_zero_ok;
    logic w_order_ok;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_MOTORS; i++) begin
                r_forced[i] <= '0;
            end
            r_thr <= THR_RESET;
            r_off <= OFF_RESET;
            r_lim <= LIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FORCED_A:  r_forced[0] <= i_cfg_wdata[CMD_WIDTH-1:0];
                REG_FORCED_B:  r_forced[1] <= i_cfg_wdata[CMD_WIDTH-1:0];
                REG_FORCED_C:  r_forced[2] <= i_cfg_wdata[CMD_WIDTH-1:0];
                REG_FORCED_D:  r_forced[3] <= i_cfg_wdata[CMD_WIDTH-1:0];
                REG_THRESHOLD: r_thr <= i_cfg_wdata[THR_W-1:0];
                REG_OFFSET:    r_off <= i_cfg_wdata[OFF_W-1:0];
                REG_LIMIT:     r_lim <= i_cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it or any stage after it has room, or the sink takes.
    for (genvar k = 0; k < NSTG; k++) begin : g_ld
        assign w_ld[k] = o_cmd.ready || !(&r_vld[OUT_S:k]);
    end

    assign i_cmd.ready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_cmd.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: forced commands win when any of them is nonzero.
    assign w_in[0]  = i_cmd.motor_a_in;
    assign w_in[1]  = i_cmd.motor_b_in;
    assign w_in[2]  = i_cmd.motor_c_in;
    assign w_in[3]  = i_cmd.motor_d_in;
    assign w_forced = (r_forced[0] != '0) || (r_forced[1] != '0) ||
                      (r_forced[2] != '0) || (r_forced[3] != '0);

    always_comb begin
        logic signed [EXT_W-1:0] v_cmd;
        logic signed [EXT_W-1:0] v_thr;
        logic signed [EXT_W-1:0] v_off;
        logic signed [EXT_W-1:0] v_frc;
        v_thr = signed'(EXT_W'(r_thr));
        v_off = signed'(EXT_W'(r_off));
        for (int i = 0; i < N_MOTORS; i++) begin
            v_cmd = EXT_W'(w_in[i]);
            v_frc = EXT_W'(r_forced[i]);
            if (w_forced) begin
                n_s1_sign[i] = (v_frc < 0);
                n_s1_mag[i]  = (v_frc < 0) ? MAG_W'(-v_frc) : MAG_W'(v_frc);
            end else if (v_cmd > v_thr) begin
                n_s1_sign[i] = 1'b0;
                n_s1_mag[i]  = MAG_W'(v_cmd + v_off);
            end else if (v_cmd < -v_thr) begin
                n_s1_sign[i] = 1'b1;
                n_s1_mag[i]  = MAG_W'(v_off - v_cmd);
            end else begin
                n_s1_sign[i] = 1'b0;
                n_s1_mag[i]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s1_sign <= n_s1_sign;
            r_s1_mag  <= n_s1_mag;
        end
    end

    // Stage 2: max of four, per-lane limit compare, and magnitude times limit.
    assign w_max01  = (r_s1_mag[0] > r_s1_mag[1]) ? r_s1_mag[0] : r_s1_mag[1];
    assign w_max23  = (r_s1_mag[2] > r_s1_mag[3]) ? r_s1_mag[2] : r_s1_mag[3];
    assign n_s2_scl = (FIN_W'(r_s1_mag[0]) > FIN_W'(r_lim)) ||
                      (FIN_W'(r_s1_mag[1]) > FIN_W'(r_lim)) ||
                      (FIN_W'(r_s1_mag[2]) > FIN_W'(r_lim)) ||
                      (FIN_W'(r_s1_mag[3]) > FIN_W'(r_lim));

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_s2_sign <= r_s1_sign;
            r_s2_mag  <= r_s1_mag;
            r_s2_max  <= (w_max01 > w_max23) ? w_max01 : w_max23;
            r_s2_scl  <= n_s2_scl;
            for (int i = 0; i < N_MOTORS; i++) begin
                r_s2_prod[i] <= PROD_W'(r_s1_mag[i]) * PROD_W'(r_lim);
            end
        end
    end

    // Divider entry: the top bits of the dividend start as the remainder,
    // which is below the max whenever scaling applies.
    assign w_dmax[0] = r_s2_max;
    for (genvar i = 0; i < N_MOTORS; i++) begin : g_entry
        assign w_drem[0][i] = r_s2_prod[i][PROD_W-1:DIV_STEPS];
        assign w_dlow[0][i] = r_s2_prod[i][DIV_STEPS-1:0];
        assign w_dquo[0][i] = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        mcdn_div_step #(
            .MAG_W (MAG_W)
        ) u_step (
            .i_clk (i_clk),
            .i_ld  (w_ld[DIV0+k]),
            .i_max (w_dmax[k]),
            .i_rem (w_drem[k]),
            .i_low (w_dlow[k]),
            .i_quo (w_dquo[k]),
            .o_max (w_dmax[k+1]),
            .o_rem (w_drem[k+1]),
            .o_low (w_dlow[k+1]),
            .o_quo (w_dquo[k+1])
        );
    end

    // Side data moves in step with the divider stages.
    always_ff @(posedge i_clk) begin
        if (w_ld[DIV0]) begin
            r_sd_sign[0] <= r_s2_sign;
            r_sd_mag[0]  <= r_s2_mag;
            r_sd_scl[0]  <= r_s2_scl;
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            if (w_ld[DIV0+k]) begin
                r_sd_sign[k] <= r_sd_sign[k-1];
                r_sd_mag[k]  <= r_sd_mag[k-1];
                r_sd_scl[k]  <= r_sd_scl[k-1];
            end
        end
    end

    // Output: pick quotient or magnitude, saturate, then apply the sign.
    always_comb begin
        for (int i = 0; i < N_MOTORS; i++) begin
            w_fin_mag[i] = r_sd_scl[DIV_STEPS-1] ? FIN_W'(w_dquo[DIV_STEPS][i])
                                                 : FIN_W'(r_sd_mag[DIV_STEPS-1][i]);
            w_fin_pos[i] = (w_fin_mag[i] > BOUND) ? CMD_WIDTH'(BOUND)
                                                  : CMD_WIDTH'(w_fin_mag[i]);
            n_out[i]     = r_sd_sign[DIV_STEPS-1][i] ? (CMD_WIDTH'(0) - w_fin_pos[i])
                                                     : w_fin_pos[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[OUT_S]) begin
            r_out     <= n_out;
            r_out_scl <= r_sd_scl[DIV_STEPS-1];
        end
    end

    assign o_cmd.valid       = r_vld[OUT_S];
    assign o_cmd.motor_a_out = r_out[0];
    assign o_cmd.motor_b_out = r_out[1];
    assign o_cmd.motor_c_out = r_out[2];
    assign o_cmd.motor_d_out = r_out[3];
    assign o_cmd.was_scaled  = r_out_scl;

    // A zero magnitude divides to zero, and quotients keep the magnitude order.
    always_comb begin
        w_zero_ok  = 1'b1;
        w_order_ok = 1'b1;
        for (int i = 0; i < N_MOTORS; i++) begin
            if ((r_sd_mag[DIV_STEPS-1][i] == '0) && (w_dquo[DIV_STEPS][i] != '0)) begin
                w_zero_ok = 1'b0;
            end
            for (int j = 0; j < N_MOTORS; j++) begin
                if ((r_sd_mag[DIV_STEPS-1][i] >= r_sd_mag[DIV_STEPS-1][j]) &&
                    (w_dquo[DIV_STEPS][i] < w_dquo[DIV_STEPS][j])) begin
                    w_order_ok = 1'b0;
                end
            end
        end
    end

    // Concurrent checks.
    `MCDN_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, !w_ld[0], &r_vld, "input stalled while the pipeline had a free stage")
    `MCDN_ASSERT_NEXT(a_stalled_stage_keeps, i_clk, i_rst_n, r_vld[OUT_S-1] && !w_ld[OUT_S-1], r_vld[OUT_S-1], "stalled divider beat was dropped")
    `MCDN_ASSERT_IMPL(a_zero_quotient, i_clk, i_rst_n, r_vld[OUT_S-1] && r_sd_scl[DIV_STEPS-1], w_zero_ok, "zero magnitude gave a nonzero quotient")
    `MCDN_ASSERT_IMPL(a_quotient_order, i_clk, i_rst_n, r_vld[OUT_S-1] && r_sd_scl[DIV_STEPS-1], w_order_ok, "scaled quotients out of magnitude order")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for motor_command_deadzone_normalizer_core: it drives command beats,
// writes the configuration while idle and checks every result against its own predictor.
// Depends on mcdn_pkg, the mcdn_in_if / mcdn_out_if interfaces and the core itself.
module tb;
    import mcdn_pkg::*;

    localparam int CMD_W = 16;
    localparam int CFG_W = (CMD_W > LIM_W) ? CMD_W : LIM_W;
    localparam int WIDE = CMD_W + 3;
    localparam int CMD_MAX = (1 << (CMD_W - 1)) - 1;
    localparam int CMD_MIN = -(1 << (CMD_W - 1));
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = DIV_STEPS + 3 + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES_PER_PROFILE = 5;
    localparam int BEATS_PER_PHASE = 50;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef logic signed [CMD_W-1:0] t_cmd_word;

    typedef struct packed {
        logic signed [CMD_W-1:0] motor_a;
        logic signed [CMD_W-1:0] motor_b;
        logic signed [CMD_W-1:0] motor_c;
        logic signed [CMD_W-1:0] motor_d;
        logic                    scaled;
    } t_conditioned;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;

    mcdn_in_if  #(.CMD_WIDTH(CMD_W)) cmd_in_bus ();
    mcdn_out_if #(.CMD_WIDTH(CMD_W)) cmd_out_bus ();

    // Shadow copy of the configuration registers.
    t_cmd_word          forced_reg [N_MOTORS] = '{default: '0};
    logic [THR_W-1:0]   thr_reg = THR_RESET;
    logic [OFF_W-1:0]   off_reg = OFF_RESET;
    logic [LIM_W-1:0]   lim_reg = LIM_RESET;

    t_conditioned       conditioned_q [$];
    int                 mismatch_cnt = 0;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 stall_cycles = 0;

    motor_command_deadzone_normalizer_core #(.CMD_WIDTH(CMD_W)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_in_bus),
        .o_cmd       (cmd_out_bus)
    );

    // 50 MHz clock.
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Works out the conditioned commands for one beat under the current settings.
    function automatic t_conditioned condition_commands(input t_cmd_word a, b, c, d);
        t_cmd_word               raw [N_MOTORS];
        logic signed [WIDE-1:0]  lane [N_MOTORS];
        logic [WIDE-1:0]         mag [N_MOTORS];
        logic signed [WIDE-1:0]  thr_w;
        logic signed [WIDE-1:0]  off_w;
        logic signed [WIDE-1:0]  bound_w;
        logic [WIDE-1:0]         peak;
        logic [WIDE+LIM_W-1:0]   quo;
        logic                    override;
        t_conditioned            r;
        int                      i;
        raw[0] = a;
        raw[1] = b;
        raw[2] = c;
        raw[3] = d;
        thr_w = {{(WIDE - THR_W){1'b0}}, thr_reg};
        off_w = {{(WIDE - OFF_W){1'b0}}, off_reg};
        bound_w = CMD_MAX;
        override = 1'b0;
        peak = '0;
        r = '0;
        for (i = 0; i < N_MOTORS; i++) begin
            if (forced_reg[i] != 0) override = 1'b1;
        end
        // Forced commands bypass the deadzone; otherwise push active commands away from zero.
        for (i = 0; i < N_MOTORS; i++) begin
            if (override) begin
                lane[i] = forced_reg[i];
            end else if (raw[i] > thr_w) begin
                lane[i] = raw[i] + off_w;
            end else if (raw[i] < -thr_w) begin
                lane[i] = raw[i] - off_w;
            end else begin
                lane[i] = '0;
            end
            mag[i] = (lane[i] < 0) ? -lane[i] : lane[i];
            if (mag[i] > peak) peak = mag[i];
        end
        // Proportional scaling on magnitudes, sign put back afterwards.
        if (peak > lim_reg) begin
            r.scaled = 1'b1;
            for (i = 0; i < N_MOTORS; i++) begin
                quo = (mag[i] * lim_reg) / peak;
                lane[i] = (lane[i] < 0) ? -$signed(quo[WIDE-1:0]) : $signed(quo[WIDE-1:0]);
            end
        end
        for (i = 0; i < N_MOTORS; i++) begin
            if (lane[i] > bound_w) lane[i] = bound_w;
            if (lane[i] < -bound_w) lane[i] = -bound_w;
        end
        r.motor_a = lane[0][CMD_W-1:0];
        r.motor_b = lane[1][CMD_W-1:0];
        r.motor_c = lane[2][CMD_W-1:0];
        r.motor_d = lane[3][CMD_W-1:0];
        return r;
    endfunction

    // One register write, after which the write enable drops again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FORCED_A, REG_FORCED_B, REG_FORCED_C, REG_FORCED_D: begin
                forced_reg[idx] = data[CMD_W-1:0];
            end
            REG_THRESHOLD: thr_reg = data[THR_W-1:0];
            REG_OFFSET:    off_reg = data[OFF_W-1:0];
            REG_LIMIT:     lim_reg = data[LIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Sends one command beat, with a random gap first, and records what it should produce.
    task automatic send_cmd(input t_cmd_word a, b, c, d);
        if ($urandom_range(99) < src_idle_pct) begin
            cmd_in_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        cmd_in_bus.valid <= 1'b1;
        cmd_in_bus.motor_a_in <= a;
        cmd_in_bus.motor_b_in <= b;
        cmd_in_bus.motor_c_in <= c;
        cmd_in_bus.motor_d_in <= d;
        do @(posedge i_clk); while (!cmd_in_bus.ready);
        conditioned_q.push_back(condition_commands(a, b, c, d));
    endtask

    // Holds the input off until every result is back and the pipeline is empty.
    task automatic wait_all_results();
        cmd_in_bus.valid <= 1'b0;
        while (conditioned_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Commands biased toward the threshold edges, the extremes and the scaling range.
    function automatic t_cmd_word rand_cmd();
        int v;
        bit flip;
        flip = $urandom_range(1);
        case ($urandom_range(4))
            0, 1: v = int'($urandom_range(65535)) + CMD_MIN;
            2: begin
                v = int'(thr_reg) + int'($urandom_range(2)) - 1;
                if (flip) v = -v;
            end
            3: begin
                case ($urandom_range(3))
                    0: v = CMD_MAX;
                    1: v = CMD_MIN;
                    2: v = 1;
                    default: v = -1;
                endcase
            end
            default: begin
                v = int'($urandom_range(12000));
                if (flip) v = -v;
            end
        endcase
        return t_cmd_word'(v);
    endfunction

    // Writes every register with a fresh random setting; junk goes in the unused upper bits.
    task automatic randomize_config();
        logic [THR_W-1:0] thr_v;
        logic [OFF_W-1:0] off_v;
        logic [LIM_W-1:0] lim_v;
        bit use_forced;
        int i;
        use_forced = ($urandom_range(4) == 0);
        for (i = 0; i < N_MOTORS; i++) begin
            if (use_forced && $urandom_range(1)) begin
                write_reg(CFG_IDX_W'(REG_FORCED_A + i), CFG_W'($urandom));
            end else begin
                write_reg(CFG_IDX_W'(REG_FORCED_A + i), '0);
            end
        end
        case ($urandom_range(3))
            0: thr_v = '0;
            1: thr_v = '1;
            2: thr_v = THR_W'($urandom_range(200));
            default: thr_v = THR_W'($urandom);
        endcase
        case ($urandom_range(3))
            0: off_v = '0;
            1: off_v = '1;
            2: off_v = OFF_W'($urandom_range(400));
            default: off_v = OFF_W'($urandom);
        endcase
        case ($urandom_range(7))
            0: lim_v = '0;
            1: lim_v = '1;
            2: lim_v = LIM_W'(1);
            3: lim_v = LIM_W'($urandom_range(1000));
            default: lim_v = LIM_W'($urandom_range(1, 32767));
        endcase
        write_reg(REG_THRESHOLD, {(CFG_W - THR_W)'($urandom), thr_v});
        write_reg(REG_OFFSET, {(CFG_W - OFF_W)'($urandom), off_v});
        write_reg(REG_LIMIT, {(CFG_W - LIM_W)'($urandom), lim_v});
    endtask

    // Reset settings: threshold edges, extremes and the scaling boundary.
    task automatic test_reset_defaults();
        send_cmd(0, 0, 0, 0);
        send_cmd(30, -30, 31, -31);
        send_cmd(CMD_MAX, CMD_MIN, 1, -1);
        send_cmd(9800, -9800, 0, 100);
        send_cmd(9801, -4000, 2000, -29);
        send_cmd(-16'sd1, 16'sh5555, -16'sh5556, 16'sh2AAA);
    endtask

    // Forced commands replace the input, including the most negative value.
    task automatic test_forced_override();
        wait_all_results();
        write_reg(REG_FORCED_A, CFG_W'(CMD_MIN));
        write_reg(REG_FORCED_B, '0);
        write_reg(REG_FORCED_C, CFG_W'(CMD_MAX));
        write_reg(REG_FORCED_D, CFG_W'(1));
        send_cmd(rand_cmd(), rand_cmd(), rand_cmd(), rand_cmd());
        send_cmd(0, 0, 0, 0);
        wait_all_results();
        write_reg(REG_FORCED_A, '0);
        write_reg(REG_FORCED_C, '0);
        write_reg(REG_FORCED_D, CFG_W'(-5));
        send_cmd(CMD_MAX, CMD_MIN, 500, -500);
        wait_all_results();
        write_reg(REG_LIMIT, CFG_W'(3));
        send_cmd(CMD_MAX, 0, 0, 0);
        wait_all_results();
        write_reg(REG_FORCED_D, '0);
    endtask

    // Register extremes: limit of zero and one, full threshold and offset, masked upper bits.
    task automatic test_register_extremes();
        wait_all_results();
        write_reg(REG_LIMIT, {1'b1, LIM_W'(0)});
        send_cmd(0, 0, 0, 0);
        send_cmd(5000, -5000, 31, 0);
        wait_all_results();
        write_reg(REG_LIMIT, CFG_W'(1));
        send_cmd(31, -31, 0, 0);
        wait_all_results();
        write_reg(REG_THRESHOLD, {4'hA, THR_W'(0)});
        write_reg(REG_OFFSET, {4'h5, {OFF_W{1'b1}}});
        write_reg(REG_LIMIT, CFG_W'(CMD_MAX));
        send_cmd(1, -1, 0, CMD_MAX);
        send_cmd(CMD_MIN, 100, -100, 0);
        wait_all_results();
        write_reg(REG_THRESHOLD, {4'hF, {THR_W{1'b1}}});
        write_reg(REG_OFFSET, '0);
        send_cmd(4095, -4095, 4096, -4096);
        wait_all_results();
        // A write to the spare index must leave every register alone.
        write_reg(REG_UNUSED, CFG_W'($urandom));
        send_cmd(4096, 20000, -20000, 1);
        wait_all_results();
        write_reg(REG_THRESHOLD, CFG_W'(THR_RESET));
        write_reg(REG_OFFSET, CFG_W'(OFF_RESET));
        write_reg(REG_LIMIT, CFG_W'(LIM_RESET));
    endtask

    // Random beats under three idling profiles, a new setting for each phase.
    task automatic test_random_traffic();
        int profile;
        int phase;
        for (profile = 0; profile < 3; profile++) begin
            case (profile)
                0: begin
                    src_idle_pct = 10;
                    sink_idle_pct = 47;
                end
                1: begin
                    src_idle_pct = 47;
                    sink_idle_pct = 10;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (phase = 0; phase < PHASES_PER_PROFILE; phase++) begin
                wait_all_results();
                randomize_config();
                repeat (BEATS_PER_PHASE) send_cmd(rand_cmd(), rand_cmd(), rand_cmd(), rand_cmd());
            end
        end
    endtask

    // Result side stalls at random.
    always @(posedge i_clk) begin
        cmd_out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic check_field(input string name, input logic [CMD_W-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatch_cnt++;
        end
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_conditioned want;
        if (i_rst_n && cmd_out_bus.valid && cmd_out_bus.ready) begin
            if (conditioned_q.size() == 0) begin
                $error("result beat with no command outstanding");
                mismatch_cnt++;
            end else begin
                want = conditioned_q.pop_front();
                check_field("motor_a_out", want.motor_a, cmd_out_bus.motor_a_out);
                check_field("motor_b_out", want.motor_b, cmd_out_bus.motor_b_out);
                check_field("motor_c_out", want.motor_c, cmd_out_bus.motor_c_out);
                check_field("motor_d_out", want.motor_d, cmd_out_bus.motor_d_out);
                check_field("was_scaled", CMD_W'(want.scaled), CMD_W'(cmd_out_bus.was_scaled));
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge i_clk) begin
        if ((cmd_in_bus.valid && cmd_in_bus.ready) || (cmd_out_bus.valid && cmd_out_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        cmd_in_bus.valid = 1'b0;
        cmd_in_bus.motor_a_in = '0;
        cmd_in_bus.motor_b_in = '0;
        cmd_in_bus.motor_c_in = '0;
        cmd_in_bus.motor_d_in = '0;
        src_idle_pct = 10;
        sink_idle_pct = 47;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_forced_override();
        test_register_extremes();
        test_random_traffic();
        wait_all_results();

        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mcdn_pkg.sv
rtl/core/mcdn_ifs.sv
rtl/core/mcdn_div_step.sv
rtl/core/motor_command_deadzone_normalizer_core.sv
tb/sv/tb.sv
